[design/mlfq_pkg.sv]
`default_nettype none
package mlfq_pkg;

    localparam int TASK_SLOTS = 128;
    localparam int BURST_BITS = 16;
    localparam int SLOT_BITS  = $clog2(TASK_SLOTS);
    localparam int CNT_BITS   = $clog2(TASK_SLOTS + 1);

    localparam logic [7:0] QUANTUM_Q1_RESET = 8'd8;
    localparam logic [7:0] QUANTUM_Q2_RESET = 8'd16;

    localparam logic [0:0] REG_QUANTUM_Q1 = 1'b0;
    localparam logic [0:0] REG_QUANTUM_Q2 = 1'b1;

    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [6:0]  task_id;
        logic [15:0] burst_len;
    } in_item_t;

    typedef struct packed {
        logic       ran;
        logic [1:0] level;
        logic [6:0] run_id;
        logic       started;
        logic       finished;
        logic       demoted;
        logic       accepted;
    } out_item_t;

endpackage
`default_nettype wire

[design/mlfq_ram.sv]
`default_nettype none
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/multilevel_feedback_queue_scheduler_top.sv]
`default_nettype none
// Three-level feedback queue scheduler. An arrival transaction (kind 0) queues a task id with
// its burst length at level 1. A tick transaction (kind 1) runs one task from the highest
// non-empty level and reports the level, id, dispatch start, finish and demotion. Every input
// transaction yields exactly one result transaction. The sequencer reads the queue head and
// the remaining work in ST_RD, executes and writes back in ST_EXEC, and presents the result
// in ST_OUT. The block takes no input while an item is in progress or its result is still
// held. A task is active while its remaining work is non-zero. For this reason, after reset
// the block clears all 128 entries of the remaining-work memory, and it holds in_stall high
// until the clear is done. The quantum registers lie at byte addresses 0 and 4, and a
// quantum written as zero acts as one tick.
module multilevel_feedback_queue_scheduler_top
    import mlfq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;
    localparam logic [2:0] ST_CLR  = 3'd4;

    logic [2:0] state_reg;
    logic [7:0] q1_reg, q2_reg;
    logic [SLOT_BITS-1:0] head_reg [3];
    logic [CNT_BITS-1:0]  cnt_reg  [3];
    logic [SLOT_BITS-1:0] clr_idx_reg;
    logic [7:0] used1_reg, used2_reg;
    logic [1:0] last_lvl_reg;
    logic [6:0] last_id_reg [2];
    in_item_t   item_reg;
    logic [1:0] lv_reg;          // 0..2 queue index, 3 all queues empty
    out_item_t  res_reg;

    // Queue memories and remaining-work memory.
    logic [2:0]           q_we;
    logic [SLOT_BITS-1:0] q_waddr [3];
    logic [6:0]           q_wdata;
    logic [6:0]           q_rdata [3];
    logic                 w_we;
    logic [SLOT_BITS-1:0] w_addr_w, w_addr_r;
    logic [BURST_BITS-1:0] w_wdata, w_rdata;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_q
            mlfq_ram #(.WIDTH(7), .DEPTH(TASK_SLOTS)) u_q (
                .clk(clk), .we(q_we[g]), .waddr(q_waddr[g]), .wdata(q_wdata),
                .raddr(head_reg[g]), .rdata(q_rdata[g]));
        end
    endgenerate

    mlfq_ram #(.WIDTH(BURST_BITS), .DEPTH(TASK_SLOTS)) u_work (
        .clk(clk), .we(w_we), .waddr(w_addr_w), .wdata(w_wdata),
        .raddr(w_addr_r), .rdata(w_rdata));

    logic [6:0] cur;
    logic [SLOT_BITS-1:0] cur_slot;
    logic [BURST_BITS-1:0] work_dec;
    logic [7:0] used_inc, qeff;
    logic id_ok, burst_ok, arr_ok, fin_now, dem_now;
    logic [BURST_BITS-1:0] burst_sat;

    always_comb
    begin
        cur      = (lv_reg == 2'd3) ? 7'd0 : q_rdata[lv_reg];
        cur_slot = cur[SLOT_BITS-1:0];
        work_dec = (w_rdata != '0) ? w_rdata - 1'b1 : w_rdata;
        fin_now  = (work_dec == '0);
        used_inc = (lv_reg == 2'd0) ? used1_reg + 8'd1 : used2_reg + 8'd1;
        qeff     = (lv_reg == 2'd0) ? ((q1_reg == 8'd0) ? 8'd1 : q1_reg)
                                    : ((q2_reg == 8'd0) ? 8'd1 : q2_reg);
        dem_now  = !fin_now && (lv_reg != 2'd2) && (used_inc >= qeff);
        id_ok    = ({25'd0, item_reg.task_id} < TASK_SLOTS);
        burst_ok = (item_reg.burst_len != 16'd0);
        // An id is active exactly while its remaining work is non-zero.
        arr_ok   = id_ok && burst_ok && (w_rdata == '0);
        burst_sat = (item_reg.burst_len > 16'(2**BURST_BITS - 1))
                  ? {BURST_BITS{1'b1}} : BURST_BITS'(item_reg.burst_len);
    end

    // Memory write controls, issued in ST_EXEC and during the clearing pass.
    always_comb
    begin
        q_we     = '0;
        q_wdata  = item_reg.task_id;
        for (int i = 0; i < 3; i++)
        begin
            q_waddr[i] = head_reg[i] + SLOT_BITS'(cnt_reg[i]);
        end
        w_we     = 1'b0;
        w_addr_w = item_reg.task_id[SLOT_BITS-1:0];
        w_wdata  = burst_sat;
        w_addr_r = (state_reg == ST_RD && item_reg.kind == KIND_TICK)
                 ? cur_slot : item_reg.task_id[SLOT_BITS-1:0];
        if (state_reg == ST_CLR)
        begin
            w_we     = 1'b1;
            w_addr_w = clr_idx_reg;
            w_wdata  = '0;
        end
        else if (state_reg == ST_EXEC)
        begin
            if (item_reg.kind == KIND_ARRIVAL)
            begin
                q_we[0] = arr_ok;
                w_we    = arr_ok;
            end
            else if (lv_reg != 2'd3)
            begin
                w_we     = 1'b1;
                w_addr_w = cur_slot;
                w_wdata  = work_dec;
                q_wdata  = cur;
                if (dem_now)
                begin
                    q_we[lv_reg + 2'd1] = 1'b1;
                end
            end
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = res_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_QUANTUM_Q2) ? {24'd0, q2_reg} : {24'd0, q1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            clr_idx_reg  <= '0;
            q1_reg       <= QUANTUM_Q1_RESET;
            q2_reg       <= QUANTUM_Q2_RESET;
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            used1_reg    <= '0;
            used2_reg    <= '0;
            last_lvl_reg <= '0;
            last_id_reg[0] <= '0;
            last_id_reg[1] <= '0;
            lv_reg       <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == REG_QUANTUM_Q1)
            begin
                q1_reg <= pwdata[7:0];
            end
            if (psel && penable && pwrite && paddr[2] == REG_QUANTUM_Q2)
            begin
                q2_reg <= pwdata[7:0];
            end
            unique case (state_reg)
                ST_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == SLOT_BITS'(TASK_SLOTS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_RD;
                        if (cnt_reg[0] != '0)      lv_reg <= 2'd0;
                        else if (cnt_reg[1] != '0) lv_reg <= 2'd1;
                        else if (cnt_reg[2] != '0) lv_reg <= 2'd2;
                        else                       lv_reg <= 2'd3;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    state_reg <= ST_OUT;
                    if (item_reg.kind == KIND_ARRIVAL)
                    begin
                        if (arr_ok)
                        begin
                            cnt_reg[0] <= cnt_reg[0] + 1'b1;
                        end
                    end
                    else if (lv_reg == 2'd3)
                    begin
                        last_lvl_reg <= 2'd0;
                    end
                    else
                    begin
                        last_lvl_reg <= lv_reg + 2'd1;
                        if (lv_reg == 2'd0) used1_reg <= (fin_now || dem_now) ? 8'd0 : used_inc;
                        if (lv_reg == 2'd1) used2_reg <= (fin_now || dem_now) ? 8'd0 : used_inc;
                        if (lv_reg != 2'd0) last_id_reg[lv_reg[1]] <= cur;
                        if (fin_now || dem_now)
                        begin
                            head_reg[lv_reg] <= head_reg[lv_reg] + 1'b1;
                            cnt_reg[lv_reg]  <= cnt_reg[lv_reg] - 1'b1;
                        end
                        if (dem_now)
                        begin
                            cnt_reg[lv_reg + 2'd1] <= cnt_reg[lv_reg + 2'd1] + 1'b1;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_EXEC)
        begin
            res_reg <= '0;
            if (item_reg.kind == KIND_ARRIVAL)
            begin
                res_reg.accepted <= arr_ok;
            end
            else if (lv_reg != 2'd3)
            begin
                res_reg.ran      <= 1'b1;
                res_reg.level    <= lv_reg + 2'd1;
                res_reg.run_id   <= cur;
                res_reg.started  <= (lv_reg == 2'd0) ? (used1_reg == 8'd0)
                                  : (last_lvl_reg != lv_reg + 2'd1
                                     || last_id_reg[lv_reg[1]] != cur);
                res_reg.finished <= fin_now;
                res_reg.demoted  <= dem_now;
            end
        end
    end

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> !out_valid)
        else $error("result before item processed");
    a_fin_dem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.finished && out_data.demoted))
        else $error("finish and demotion together");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= TASK_SLOTS) && (cnt_reg[1] <= TASK_SLOTS) && (cnt_reg[2] <= TASK_SLOTS))
        else $error("queue count overflow");
`endif
endmodule
`default_nettype wire
